// ----- hw/rtl/sbdt_pkg.sv -----
// ----------------------------------------------------------------------------
// sbdt_pkg
// Shared types and constants for the signed binary to decimal text core.
// ----------------------------------------------------------------------------
package sbdt_pkg;

  localparam int IN_WIDTH   = 64;
  localparam int CHAR_WIDTH = 6;

  localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 6'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BCD_HOLD,
    BCD_CLEAR,
    BCD_DABBLE,
    BCD_SHIFT_DIGIT
  } bcd_op_t;

endpackage

// ----- hw/rtl/sbdt_bcd_shift.sv -----
// ----------------------------------------------------------------------------
// sbdt_bcd_shift
// BCD shift register: add-3 and shift one binary bit in per cycle while op is
// BCD_DABBLE, then shift decimal digits out from the most significant end.
// ----------------------------------------------------------------------------
module sbdt_bcd_shift #(
  parameter int NDIG = 19
) (
  input  logic             clk,
  input  sbdt_pkg::bcd_op_t op,
  input  logic             bit_in,
  output logic [3:0]       top_digit
);
  import sbdt_pkg::*;

  logic [4*NDIG-1:0] bcd_r;
  logic [4*NDIG-1:0] bcd_nxt;
  logic [4*NDIG-1:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    unique case (op)
      BCD_HOLD:        bcd_nxt = bcd_r;
      BCD_CLEAR:       bcd_nxt = '0;
      BCD_DABBLE:      bcd_nxt = {adj[4*NDIG-2:0], bit_in};
      BCD_SHIFT_DIGIT: bcd_nxt = {bcd_r[4*NDIG-5:0], 4'd0};
      default:         bcd_nxt = bcd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[4*NDIG-1 -: 4];

endmodule

// ----- hw/rtl/signed_binary_to_decimal_text_core.sv -----
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_text_core
// Converts a signed two's-complement value to its decimal ASCII text, one
// character per beat: optional minus sign, then digits without leading zeros.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  input     in_value                            start & !busy
//  result    out_character, out_last             out_valid strobe, one cycle
//
//  a value runs the shift-add-3 pass, one bit a cycle, then emits a minus
//  sign if negative, then the digit shift-out, one digit a cycle
//  busy is high from accept until the last character has been strobed
//  rst_n is synchronous, active low, and returns the core to idle
//  results cannot be stalled; each beat is valid for exactly one cycle
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_text_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sbdt_pkg::IN_WIDTH-1:0] in_value,
  output logic                                 out_valid,
  output logic [sbdt_pkg::CHAR_WIDTH-1:0]      out_character,
  output logic                                 out_last
);
  import sbdt_pkg::*;

  localparam int NDIG   = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCNT_W = $clog2(VALUE_WIDTH);
  localparam int DCNT_W = $clog2(NDIG + 1);

  state_t state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCNT_W-1:0]      bcnt_r, bcnt_nxt;
  logic [DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   started_r, started_nxt;
  logic [VALUE_WIDTH-1:0] v_in;
  bcd_op_t                op;
  logic [3:0]             top_digit;

  assign v_in = in_value[VALUE_WIDTH-1:0];

  sbdt_bcd_shift #(
    .NDIG (NDIG)
  ) u_bcd (
    .clk       (clk),
    .op        (op),
    .bit_in    (mag_r[VALUE_WIDTH-1]),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcnt_nxt      = bcnt_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    op            = BCD_HOLD;
    out_valid     = 1'b0;
    out_character = CH_ZERO;
    out_last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          neg_nxt     = v_in[VALUE_WIDTH-1];
          mag_nxt     = v_in[VALUE_WIDTH-1] ? (~v_in + 1'b1) : v_in;
          bcnt_nxt    = BCNT_W'(VALUE_WIDTH - 1);
          dcnt_nxt    = DCNT_W'(NDIG);
          started_nxt = 1'b0;
          op          = BCD_CLEAR;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        op       = BCD_DABBLE;
        mag_nxt  = {mag_r[VALUE_WIDTH-2:0], 1'b0};
        bcnt_nxt = bcnt_r - 1'b1;
        if (bcnt_r == '0) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        out_valid     = 1'b1;
        out_character = CH_MINUS;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        op       = BCD_SHIFT_DIGIT;
        dcnt_nxt = dcnt_r - 1'b1;
        if (started_r || top_digit != 4'd0 || dcnt_r == DCNT_W'(1)) begin
          out_valid     = 1'b1;
          out_character = CH_ZERO + {2'b00, top_digit};
          out_last      = (dcnt_r == DCNT_W'(1));
          started_nxt   = 1'b1;
        end
        if (dcnt_r == DCNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    bcnt_r    <= bcnt_nxt;
    dcnt_r    <= dcnt_nxt;
    neg_r     <= neg_nxt;
    started_r <= started_nxt;
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for signed_binary_to_decimal_text_core. Signed values
// are queued and sent over the start/busy command port with varied gaps. Each
// accepted value is turned into the decimal text it should produce: an
// optional minus sign, then digits without leading zeros, with the final
// character flagged. The character strobes are checked against that text in
// order, and a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module tb;
  import sbdt_pkg::*;

  localparam int VW = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int NUM_RANDOM = 400;
  localparam int MAX_REPORTS = 50;
  localparam logic [IN_WIDTH-1:0] WIDTH_MASK =
    (VW == IN_WIDTH) ? {IN_WIDTH{1'b1}} : ((64'd1 << VW) - 64'd1);

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] character;
    logic                  is_last;
  } text_beat_t;

  typedef struct {
    logic [IN_WIDTH-1:0] value;
    bit                  drain_first;
  } queued_value_t;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic signed [IN_WIDTH-1:0] in_value;
  logic                       out_valid;
  logic [CHAR_WIDTH-1:0]      out_character;
  logic                       out_last;

  queued_value_t values_to_send[$];
  text_beat_t    expected_text[$];
  int            values_accepted = 0;
  int            mismatch_count = 0;
  int            quiet_cycles = 0;

  signed_binary_to_decimal_text_core #(
    .VALUE_WIDTH(VW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // decimal text of one value, appended to the expected characters
  task automatic push_decimal_text(input logic [IN_WIDTH-1:0] raw);
    logic [IN_WIDTH-1:0] bits_in;
    logic [IN_WIDTH-1:0] magnitude;
    logic                negative;
    logic [3:0]          digits[$];
    text_beat_t          beat;
    bits_in   = raw & WIDTH_MASK;
    negative  = bits_in[VW-1];
    magnitude = negative ? ((~bits_in + 64'd1) & WIDTH_MASK) : bits_in;
    if (magnitude == '0) begin
      digits.push_back(4'd0);
    end
    while (magnitude != '0) begin
      digits.push_front(4'(magnitude % 64'd10));
      magnitude = magnitude / 64'd10;
    end
    if (negative) begin
      beat.character = CH_MINUS;
      beat.is_last   = 1'b0;
      expected_text.push_back(beat);
    end
    foreach (digits[i]) begin
      beat.character = CH_ZERO + CHAR_WIDTH'(digits[i]);
      beat.is_last   = (i == digits.size() - 1);
      expected_text.push_back(beat);
    end
  endtask

  task automatic queue_value(input logic [IN_WIDTH-1:0] value, input bit drain_first);
    queued_value_t item;
    item.value       = value;
    item.drain_first = drain_first;
    values_to_send.push_back(item);
  endtask

  function automatic logic [IN_WIDTH-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    bit launch;
    if (!rst_n) begin
      start    <= 1'b0;
      in_value <= '0;
    end else begin
      if (start && !busy) begin
        push_decimal_text(in_value);
        void'(values_to_send.pop_front());
        values_accepted++;
      end
      if (!start || !busy) begin
        launch = 1'b0;
        if (values_to_send.size() > 0) begin
          if (values_to_send[0].drain_first) begin
            launch = (expected_text.size() == 0) && !out_valid;
          end else if (values_accepted >= 200 && values_accepted < 300) begin
            launch = 1'b1;
          end else begin
            launch = ($urandom_range(99) >= 16);
          end
        end
        if (launch) begin
          start    <= 1'b1;
          in_value <= values_to_send[0].value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_proc
    text_beat_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b",
                                  out_character, out_last));
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.character) begin
          report_mismatch($sformatf("character got %0d want %0d",
                                    out_character, want.character));
        end
        if (out_last !== want.is_last) begin
          report_mismatch($sformatf("last got %0b want %0b on character %0d",
                                    out_last, want.is_last, want.character));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus_proc
    logic [IN_WIDTH-1:0] v;
    logic [IN_WIDTH-1:0] pow10;
    int                  k;
    rst_n = 1'b0;

    // directed: zero, single digits, boundaries of digit counts, extremes
    queue_value(64'd0, 1'b0);
    queue_value(64'd1, 1'b0);
    queue_value(-64'd1, 1'b0);
    queue_value(64'd9, 1'b0);
    queue_value(64'd10, 1'b0);
    queue_value(-64'd10, 1'b0);
    queue_value(64'd99, 1'b0);
    queue_value(64'd100, 1'b0);
    queue_value(-64'd9, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b1);
    queue_value(64'h8000_0000_0000_0001, 1'b0);
    queue_value(64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
    queue_value(64'd999_999_999_999_999_999, 1'b0);
    queue_value(64'd1_000_000_000_000_000_000, 1'b0);
    queue_value(-64'd999_999_999_999_999_999, 1'b0);
    queue_value(-64'd1_000_000_000_000_000_000, 1'b0);
    queue_value(64'h5555_5555_5555_5555, 1'b0);
    queue_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_value(64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_value(64'h8000_0000_0000_0000, 1'b0);
    queue_value(64'd0, 1'b0);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      case ($urandom_range(5))
        0: v = random_word();
        1, 2: begin
          v = random_word() >> $urandom_range(63);
          if ($urandom_range(1)) v = -v;
        end
        3: begin
          k = $urandom_range(18);
          pow10 = 64'd1;
          for (int j = 0; j < k; j++) pow10 = pow10 * 64'd10;
          v = pow10 + 64'($urandom_range(2)) - 64'd1;
          if ($urandom_range(1)) v = -v;
        end
        4: begin
          v = 64'($urandom_range(1000));
          if ($urandom_range(1)) v = -v;
        end
        default: begin
          if ($urandom_range(1)) v = 64'h8000_0000_0000_0000 + 64'($urandom_range(3));
          else v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
        end
      endcase
      queue_value(v, (n % 60) == 59);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (values_to_send.size() != 0) @(posedge clk);
    @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sbdt_pkg.sv
hw/rtl/sbdt_bcd_shift.sv
hw/rtl/signed_binary_to_decimal_text_core.sv
dv/tb.sv
